FILE: rtl/core/bstok_pkg.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: shared package
// Token kinds, error codes, lexer modes, the result record and the keyword
// lookup used by the lexer, the token queue and the port checker.
// ----------------------------------------------------------------------------
package bstok_pkg;

	// Default widths and limits
	localparam int POS_BITS_DEF      = 16;
	localparam int KEYWORD_CHARS_DEF = 8;

	// Results per source byte and token queue depth (a power of two)
	localparam int TQ_MAX   = 3;
	localparam int TQ_DEPTH = 8;
	localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
	localparam int TQ_LVL_W = $clog2(TQ_DEPTH + 1);

	// Token kinds
	localparam logic [4:0] K_NEWLINE  = 5'd0;
	localparam logic [4:0] K_EOF      = 5'd1;
	localparam logic [4:0] K_NUMBER   = 5'd2;
	localparam logic [4:0] K_IDENT    = 5'd3;
	localparam logic [4:0] K_STRING   = 5'd4;
	localparam logic [4:0] K_KEYWORD0 = 5'd5;
	localparam logic [4:0] K_EQ       = 5'd16;
	localparam logic [4:0] K_PLUS     = 5'd17;
	localparam logic [4:0] K_MINUS    = 5'd18;
	localparam logic [4:0] K_ASTERISK = 5'd19;
	localparam logic [4:0] K_SLASH    = 5'd20;
	localparam logic [4:0] K_EQEQ     = 5'd21;
	localparam logic [4:0] K_NOTEQ    = 5'd22;
	localparam logic [4:0] K_LT       = 5'd23;
	localparam logic [4:0] K_LTEQ     = 5'd24;
	localparam logic [4:0] K_GT       = 5'd25;
	localparam logic [4:0] K_GTEQ     = 5'd26;

	// Error codes
	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_LONE_BANG  = 3'd1;
	localparam logic [2:0] E_BAD_STRING = 3'd2;
	localparam logic [2:0] E_BAD_FRAC   = 3'd3;
	localparam logic [2:0] E_UNEXPECTED = 3'd4;

	// Pending operator codes
	localparam logic [1:0] PEND_EQ   = 2'd0;
	localparam logic [1:0] PEND_BANG = 2'd1;
	localparam logic [1:0] PEND_GT   = 2'd2;
	localparam logic [1:0] PEND_LT   = 2'd3;

	typedef enum logic [3:0] {
		LM_IDLE,
		LM_COMMENT,
		LM_STRING,
		LM_NUM_INT,
		LM_NUM_DOT,
		LM_NUM_FRAC,
		LM_WORD,
		LM_OP,
		LM_ERROR
	} lex_mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start_pos;
		logic [15:0] length;
		logic [2:0]  error_code;
		logic        last;
	} tok_t;

	// Up to three results written into the token queue in one cycle
	typedef struct packed {
		logic [1:0]              n;
		tok_t [TQ_MAX-1:0]       item;
	} tok_push_t;

	// Keywords, right-aligned in the 64-bit capture register, in kind order
	localparam int KW_COUNT = 11;
	localparam logic [63:0] KW_CODE [KW_COUNT] = '{
		64'h0000_004C_4142_454C,  // LABEL
		64'h0000_0000_474F_544F,  // GOTO
		64'h0000_0050_5249_4E54,  // PRINT
		64'h0000_0049_4E50_5554,  // INPUT
		64'h0000_0000_004C_4554,  // LET
		64'h0000_0000_0000_4946,  // IF
		64'h0000_0000_5448_454E,  // THEN
		64'h0000_0045_4E44_4946,  // ENDIF
		64'h0000_0057_4849_4C45,  // WHILE
		64'h0000_5245_5045_4154,  // REPEAT
		64'h454E_4457_4849_4C45   // ENDWHILE
	};

	function automatic logic [4:0] kw_kind(input logic [63:0] word);
		logic [4:0] k;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (word == KW_CODE[i]) begin
				k = K_KEYWORD0 + 5'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [4:0] op_single(input logic [1:0] pend);
		logic [4:0] k;
		unique case (pend)
			PEND_EQ:   k = K_EQ;
			PEND_GT:   k = K_GT;
			PEND_LT:   k = K_LT;
			default:   k = K_NEWLINE;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] op_double(input logic [1:0] pend);
		logic [4:0] k;
		unique case (pend)
			PEND_EQ:   k = K_EQEQ;
			PEND_BANG: k = K_NOTEQ;
			PEND_GT:   k = K_GTEQ;
			default:   k = K_LTEQ;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/core/bstok_in_if.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: source byte channel
// Valid/ready channel carrying one source byte and the end-of-source mark.
// ----------------------------------------------------------------------------
interface bstok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source (output valid, output ch, output at_end, input ready);
	modport sink   (input valid, input ch, input at_end, output ready);
endinterface

FILE: rtl/core/bstok_out_if.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: token channel
// Valid/ready channel carrying one token record per request.
// ----------------------------------------------------------------------------
interface bstok_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [15:0] start_pos;
	logic [15:0] length;
	logic [2:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output start_pos, output length,
		output error_code, output last, input ready);
	modport sink   (input valid, input kind, input start_pos, input length,
		input error_code, input last, output ready);
endinterface

FILE: rtl/core/bstok_lexer.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: lexer stage
// Input register, lexer state and the single-pass step that turns one byte
// into up to three token records for the token queue.
// ----------------------------------------------------------------------------
module bstok_lexer
	import bstok_pkg::*;
#(
	parameter int POS_BITS      = POS_BITS_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	bstok_in_if.sink            text,
	input  logic [TQ_LVL_W-1:0] tq_level,
	output tok_push_t           push
);

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BANG  = 8'd33;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_PCT   = 8'd37;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_LESS  = 8'd60;
	localparam logic [7:0] CH_EQ    = 8'd61;
	localparam logic [7:0] CH_MORE  = 8'd62;
	localparam logic [7:0] CH_BSL   = 8'd92;

	localparam int SUM_W = TQ_LVL_W + 1;

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       at_end_s1;

	// Lexer state
	lex_mode_t           mode_q, mode_d;
	logic [POS_BITS-1:0] tstart_q, tstart_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [63:0]         wcap_q, wcap_d;
	logic                wlong_q, wlong_d;
	logic [1:0]          pend_q, pend_d;

	logic [7:0]          c;
	logic [POS_BITS-1:0] pos_inc;
	logic [POS_BITS-1:0] span_raw;
	logic [15:0]         span16;
	logic                is_digit, is_alpha;
	logic                ra_v, rb_v, eof_v, go_b;
	tok_t                ra, rb, eof_tok;
	logic [SUM_W-1:0]    level_sum;

	function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] start,
		input logic [15:0] len, input logic [2:0] err);
		tok_t t;
		t.kind       = kind;
		t.start_pos  = start;
		t.length     = len;
		t.error_code = err;
		t.last       = 1'b0;
		return t;
	endfunction

	// Room for the byte in the input register and for the next one
	assign level_sum  = SUM_W'(tq_level) + (valid_s1 ? SUM_W'(TQ_MAX) : '0);
	assign text.ready = (level_sum <= SUM_W'(TQ_DEPTH - TQ_MAX));

	// The byte in the input register is lexed while it is held there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text.valid && text.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			ch_s1     <= text.ch;
			at_end_s1 <= text.at_end;
		end
	end

	// An end of source is handled as a newline at the current position
	assign c        = at_end_s1 ? CH_LF : ch_s1;
	assign pos_inc  = (pos_q == {POS_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
	assign span_raw = (pos_q >= tstart_q) ? pos_q - tstart_q : '0;
	assign span16   = (32'(span_raw) > 32'hFFFF) ? 16'hFFFF : 16'(span_raw);
	assign is_digit = (c >= 8'd48) && (c <= 8'd57);
	assign is_alpha = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
	assign eof_tok  = mk_tok(K_EOF, 16'(pos_inc), 16'd0, E_NONE);

	always_comb begin
		mode_d   = mode_q;
		tstart_d = tstart_q;
		pos_d    = pos_q;
		wcap_d   = wcap_q;
		wlong_d  = wlong_q;
		pend_d   = pend_q;
		ra_v     = 1'b0;
		ra       = '0;
		rb_v     = 1'b0;
		rb       = '0;
		go_b     = 1'b0;
		eof_v    = 1'b0;

		// Continue or close the token in progress
		unique case (mode_q)
			LM_ERROR: begin
			end
			LM_COMMENT: begin
				if (c == CH_LF) begin
					mode_d = LM_IDLE;
					go_b   = 1'b1;
				end
			end
			LM_STRING: begin
				if (c == CH_QUOTE) begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(K_STRING, 16'(tstart_q), span16, E_NONE);
				end else if (c == CH_CR || c == CH_LF || c == CH_BSL || c == CH_TAB
					|| c == CH_PCT) begin
					mode_d = LM_ERROR;
					ra_v   = 1'b1;
					ra     = mk_tok(K_NEWLINE, 16'(pos_q), 16'd0, E_BAD_STRING);
				end
			end
			LM_NUM_INT: begin
				if (c == CH_DOT) begin
					mode_d = LM_NUM_DOT;
				end else if (!is_digit) begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(K_NUMBER, 16'(tstart_q), span16, E_NONE);
					go_b   = 1'b1;
				end
			end
			LM_NUM_DOT: begin
				if (is_digit) begin
					mode_d = LM_NUM_FRAC;
				end else begin
					mode_d = LM_ERROR;
					ra_v   = 1'b1;
					ra     = mk_tok(K_NEWLINE, 16'(pos_q), 16'd0, E_BAD_FRAC);
				end
			end
			LM_NUM_FRAC: begin
				if (!is_digit) begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(K_NUMBER, 16'(tstart_q), span16, E_NONE);
					go_b   = 1'b1;
				end
			end
			LM_WORD: begin
				if (is_digit || is_alpha) begin
					if (wcap_q[63:56] != 8'd0 || 32'(span16) >= 32'(KEYWORD_CHARS)) begin
						wlong_d = 1'b1;
					end else begin
						wcap_d = {wcap_q[55:0], c};
					end
				end else begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(wlong_q ? K_IDENT : kw_kind(wcap_q), 16'(tstart_q),
						span16, E_NONE);
					go_b   = 1'b1;
				end
			end
			LM_OP: begin
				if (c == CH_EQ) begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(op_double(pend_q), 16'(tstart_q), 16'd2, E_NONE);
				end else if (pend_q == PEND_BANG) begin
					mode_d = LM_ERROR;
					ra_v   = 1'b1;
					ra     = mk_tok(K_NEWLINE, 16'(pos_q), 16'd0, E_LONE_BANG);
				end else begin
					mode_d = LM_IDLE;
					ra_v   = 1'b1;
					ra     = mk_tok(op_single(pend_q), 16'(tstart_q), 16'd1, E_NONE);
					go_b   = 1'b1;
				end
			end
			default: begin
				mode_d = LM_IDLE;
				go_b   = 1'b1;
			end
		endcase

		// Between tokens: start a new one or emit a single-byte token
		if (go_b) begin
			tstart_d = pos_q;
			unique case (c)
				CH_SPACE, CH_TAB, CH_CR: begin
				end
				CH_HASH: mode_d = LM_COMMENT;
				CH_LF: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_NEWLINE, 16'(pos_q), 16'd1, E_NONE);
				end
				CH_NUL: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_EOF, 16'(pos_q), 16'd0, E_NONE);
				end
				CH_PLUS: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_PLUS, 16'(pos_q), 16'd1, E_NONE);
				end
				CH_MINUS: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_MINUS, 16'(pos_q), 16'd1, E_NONE);
				end
				CH_STAR: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_ASTERISK, 16'(pos_q), 16'd1, E_NONE);
				end
				CH_SLASH: begin
					rb_v = 1'b1;
					rb   = mk_tok(K_SLASH, 16'(pos_q), 16'd1, E_NONE);
				end
				CH_EQ: begin
					pend_d = PEND_EQ;
					mode_d = LM_OP;
				end
				CH_BANG: begin
					pend_d = PEND_BANG;
					mode_d = LM_OP;
				end
				CH_MORE: begin
					pend_d = PEND_GT;
					mode_d = LM_OP;
				end
				CH_LESS: begin
					pend_d = PEND_LT;
					mode_d = LM_OP;
				end
				CH_QUOTE: begin
					tstart_d = pos_inc;
					mode_d   = LM_STRING;
				end
				default: begin
					if (is_digit) begin
						mode_d = LM_NUM_INT;
					end else if (is_alpha) begin
						mode_d  = LM_WORD;
						wcap_d  = {56'd0, c};
						wlong_d = 1'b0;
					end else begin
						mode_d = LM_ERROR;
						rb_v   = 1'b1;
						rb     = mk_tok(K_NEWLINE, 16'(pos_q), 16'd0, E_UNEXPECTED);
					end
				end
			endcase
		end

		// End of source outside the error mode: closing EOF, then back to the state after reset
		if (at_end_s1) begin
			if (mode_d != LM_ERROR) begin
				eof_v    = 1'b1;
				mode_d   = LM_IDLE;
				tstart_d = '0;
				pos_d    = '0;
				wcap_d   = '0;
				wlong_d  = 1'b0;
				pend_d   = PEND_EQ;
			end
		end else begin
			pos_d = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= LM_IDLE;
			tstart_q <= '0;
			pos_q    <= '0;
			wcap_q   <= '0;
			wlong_q  <= 1'b0;
			pend_q   <= PEND_EQ;
		end else if (valid_s1) begin
			mode_q   <= mode_d;
			tstart_q <= tstart_d;
			pos_q    <= pos_d;
			wcap_q   <= wcap_d;
			wlong_q  <= wlong_d;
			pend_q   <= pend_d;
		end
	end

	// Pack the results in order and mark the final one
	always_comb begin
		logic [1:0] cnt;
		cnt       = 2'd0;
		push.item = '0;
		if (valid_s1 && ra_v) begin
			push.item[cnt] = ra;
			cnt            = cnt + 2'd1;
		end
		if (valid_s1 && rb_v) begin
			push.item[cnt] = rb;
			cnt            = cnt + 2'd1;
		end
		if (valid_s1 && eof_v) begin
			push.item[cnt] = eof_tok;
			cnt            = cnt + 2'd1;
		end
		if (cnt != 2'd0) begin
			push.item[cnt - 2'd1].last = 1'b1;
		end
		push.n = cnt;
	end

endmodule

FILE: rtl/core/bstok_tok_fifo.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: token queue
// Small queue that takes up to three token records a cycle and hands one
// per request to the token channel.
// ----------------------------------------------------------------------------
module bstok_tok_fifo
	import bstok_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  tok_push_t           push,
	output logic [TQ_LVL_W-1:0] level,
	bstok_out_if.source         tokens
);

	tok_t                mem [TQ_DEPTH];
	logic [TQ_PTR_W-1:0] wr_ptr, rd_ptr;
	logic                pop;
	tok_t                head;

	assign pop          = tokens.valid && tokens.ready;
	assign head         = mem[rd_ptr];
	assign tokens.valid = (level != '0);
	assign tokens.kind       = head.kind;
	assign tokens.start_pos  = head.start_pos;
	assign tokens.length     = head.length;
	assign tokens.error_code = head.error_code;
	assign tokens.last       = head.last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < TQ_MAX; i++) begin
			if (i < int'(push.n)) begin
				mem[wr_ptr + TQ_PTR_W'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr <= '0;
			rd_ptr <= '0;
			level  <= '0;
		end else begin
			wr_ptr <= wr_ptr + TQ_PTR_W'(push.n);
			if (pop) begin
				rd_ptr <= rd_ptr + 1'b1;
			end
			level <= level + TQ_LVL_W'(push.n) - TQ_LVL_W'(pop);
		end
	end

endmodule

FILE: rtl/core/basic_source_tokenizer_core.sv
// A byte accepted into the input register is lexed in the cycle after acceptance;
// its tokens are written into the token queue, which offers them on the token channel.
// Throughput: one source byte per cycle while the eight-entry token queue keeps room
// for three tokens for each byte in flight; tokens leave at one per cycle while ready is high.
// Reset: arst_n empties the queue and returns the lexer to idle at position zero,
// clearing a sticky error.
// ----------------------------------------------------------------------------
// BASIC source tokeniser: top level
// Streaming lexer for a small BASIC dialect. Each source byte goes through an
// input register, is lexed in a single pass against the lexer state, and the
// resulting tokens (none, one, two, or three at end of source) are written
// into a short queue that drives the token channel.
// ----------------------------------------------------------------------------
module basic_source_tokenizer_core
	import bstok_pkg::*;
#(
	parameter int POS_BITS      = POS_BITS_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bstok_in_if.sink    text,
	bstok_out_if.source tokens
);

	// The queue fill level tells the lexer whether another byte may enter:
	// the byte held in the input register and the new one may each produce
	// up to three tokens, so both must fit before ready is raised.
	logic [TQ_LVL_W-1:0] tq_level;

	// Tokens written in one cycle travel as one record with their count.
	tok_push_t tq_push;

	// The lexer holds the mode, the token start, the saturating position and
	// the word capture used for keyword matching. Errors park it in a sticky
	// error mode that only reset leaves.
	bstok_lexer #(
		.POS_BITS      (POS_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.tq_level (tq_level),
		.push     (tq_push)
	);

	// The token queue separates the two sides, so a stalled consumer does not
	// stop bytes from entering until the queue is close to full.
	bstok_tok_fifo u_tok_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.level  (tq_level),
		.tokens (tokens)
	);

endmodule

FILE: rtl/core/bstok_checker.sv
// ----------------------------------------------------------------------------
// BASIC source tokeniser: port checker
// Assertions on the token channel as seen at the top-level ports, bound to
// the top level.
// ----------------------------------------------------------------------------
module bstok_checker
	import bstok_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  kind,
	input logic [15:0] length,
	input logic [2:0]  error_code,
	input logic        last
);

	// A stalled token holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(length)
			&& $stable(error_code) && $stable(last))
		else $error("token changed while stalled");

	// An error is a bare newline record and ends the results of its byte
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != E_NONE |-> kind == K_NEWLINE && length == 16'd0 && last)
		else $error("malformed error record");

	// Newline tokens are one byte and EOF tokens are empty
	a_fixed_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == E_NONE && (kind == K_NEWLINE || kind == K_EOF)
			|-> length == ((kind == K_NEWLINE) ? 16'd1 : 16'd0))
		else $error("bad newline or EOF length");

	// Only defined error codes appear
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= E_UNEXPECTED)
		else $error("undefined error code");

endmodule

bind basic_source_tokenizer_core bstok_checker u_bstok_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (tokens.valid),
	.out_ready  (tokens.ready),
	.kind       (tokens.kind),
	.length     (tokens.length),
	.error_code (tokens.error_code),
	.last       (tokens.last)
);
